### rtl/core/dtf_pkg.sv
// ----------------------------------------------------------------------------
// dtf_pkg: shared types and constants for the decimal-to-fraction reducer
// Holds the item format passed from the front end to the reduction engine,
// the engine state encoding and the radix-16 divide-by-five digit step.
// ----------------------------------------------------------------------------
`default_nettype none

package dtf_pkg;

    localparam int VALUE_W      = 32;
    localparam int NUM_OUT_W    = 30;
    localparam int DEN_OUT_W    = 14;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_DEN_DEF  = 10000;

    // The queue depth must be a power of two so that the pointers wrap naturally.
    localparam int QUEUE_DEPTH  = 2;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_ROUND,
        S_HALVE,
        S_DIV5,
        S_DONE
    } t_state;

    // One radix-16 step of a long division by five.
    // Returns the quotient digit in bits 6:3 and the new remainder in bits 2:0.
    function automatic logic [6:0] f_div5_step(input logic [2:0] rem, input logic [3:0] nib);
        logic [6:0]  t;
        logic [14:0] p;
        logic [3:0]  q;
        logic [6:0]  qx5;
        logic [6:0]  r;
        t   = {rem, nib};
        p   = 15'(t) * 15'd205;
        q   = p[13:10];
        qx5 = 7'({q, 2'b00}) + 7'(q);
        r   = t - qx5;
        return {q, r[2:0]};
    endfunction

endpackage

`default_nettype wire

### rtl/core/dtf_queue.sv
// ----------------------------------------------------------------------------
// dtf_queue: short item queue between front end and reduction engine
// A small circular buffer that lets the front end keep accepting while the
// engine works on an earlier item.
// ----------------------------------------------------------------------------
`default_nettype none

module dtf_queue
    import dtf_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_item i_item,
    output logic  o_full,
    input  wire   i_pop,
    output t_item o_item,
    output logic  o_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;
    logic              wr_en;
    logic              rd_en;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/dtf_front.sv
// ----------------------------------------------------------------------------
// dtf_front: input stage of the decimal-to-fraction reducer
// Accepts fixed-point values, splits them into sign and magnitude and
// forwards the classified request into the item queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dtf_front
    import dtf_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_push,
    output logic                      o_full,
    input  wire signed [VALUE_W-1:0]  i_value,
    output logic                      o_q_push,
    output t_item                     o_q_item,
    input  wire                       i_q_full
);

    logic               r_valid;
    t_item              r_item;
    t_item              cls_item;
    logic [VALUE_W-1:0] raw;
    logic               accept;

    assign raw          = $unsigned(i_value);
    assign cls_item.neg = raw[VALUE_W-1];
    assign cls_item.mag = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

    assign o_q_push = r_valid && !i_q_full;
    assign o_q_item = r_item;
    assign o_full   = r_valid && i_q_full;
    assign accept   = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= cls_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

### rtl/core/dtf_back.sv
// ----------------------------------------------------------------------------
// dtf_back: reduction engine of the decimal-to-fraction reducer
// Scales the magnitude by ten until exact or capped, rounds, cancels common
// factors of two and five, and holds the finished fraction in an output
// register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dtf_back
    import dtf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int DEN_LIMIT = MAX_DEN_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_q_empty,
    input  t_item                       i_q_item,
    output logic                        o_q_pop,
    input  wire                         i_pop,
    output logic                        o_empty,
    output logic signed [NUM_OUT_W-1:0] o_numerator,
    output logic [DEN_OUT_W-1:0]        o_denominator
);

    localparam int DEN_W  = $clog2(DEN_LIMIT * 10);
    localparam int PROD_W = VALUE_W + DEN_W;
    localparam int NUM_W  = PROD_W - FRAC_BITS + 1;
    localparam int GW     = ((NUM_W + 3) / 4) * 4;
    localparam int DIGITS = GW / 4;
    localparam int CNT_W  = $clog2(DIGITS);
    localparam int NX_W   = (GW > NUM_OUT_W) ? GW : NUM_OUT_W;
    localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [GW-1:0]   MAX_G = GW'(DEN_LIMIT);

    t_state                r_state;
    t_state                n_state;
    logic                  r_neg,       n_neg;
    logic [PROD_W-1:0]     r_scaled,    n_scaled;
    logic [GW-1:0]         r_num,       n_num;
    logic [GW-1:0]         r_den,       n_den;
    logic [GW-1:0]         r_wn,        n_wn;
    logic [GW-1:0]         r_wd,        n_wd;
    logic [2:0]            r_rn,        n_rn;
    logic [2:0]            r_rd,        n_rd;
    logic [CNT_W-1:0]      r_cnt,       n_cnt;
    logic                  r_out_valid, n_out_valid;
    logic [NUM_OUT_W-1:0]  r_out_num,   n_out_num;
    logic [DEN_OUT_W-1:0]  r_out_den,   n_out_den;

    logic                  out_free;
    logic                  scale_more;
    logic                  last_digit;
    logic                  rems_zero;
    logic                  num_zero;
    logic                  both_even;
    logic [PROD_W:0]       rnd_sum;
    logic [6:0]            step_n;
    logic [6:0]            step_d;
    logic [GW-1:0]         quot_n;
    logic [GW-1:0]         quot_d;
    logic [NX_W-1:0]       num_x;
    logic [NX_W-1:0]       num_signed;

    assign out_free   = !r_out_valid || i_pop;
    assign scale_more = (r_scaled[FRAC_BITS-1:0] != '0) && (r_den < MAX_G);
    assign rnd_sum    = {1'b0, r_scaled} + HALF;
    assign num_zero   = (r_num == '0);
    assign both_even  = !r_num[0] && !r_den[0];
    assign step_n     = f_div5_step(r_rn, r_wn[GW-1 -: 4]);
    assign step_d     = f_div5_step(r_rd, r_wd[GW-1 -: 4]);
    assign quot_n     = {r_wn[GW-5:0], step_n[6:3]};
    assign quot_d     = {r_wd[GW-5:0], step_d[6:3]};
    assign last_digit = (r_cnt == CNT_W'(DIGITS - 1));
    assign rems_zero  = (step_n[2:0] == 3'd0) && (step_d[2:0] == 3'd0);
    assign num_x      = NX_W'(r_num);
    assign num_signed = r_neg ? (NX_W'(0) - num_x) : num_x;

    assign o_empty       = !r_out_valid;
    assign o_numerator   = $signed(r_out_num);
    assign o_denominator = r_out_den;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                if (!scale_more) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_state = S_HALVE;
            end
            S_HALVE: begin
                if (num_zero) begin
                    n_state = S_DONE;
                end else if (!both_even) begin
                    n_state = S_DIV5;
                end
            end
            S_DIV5: begin
                if (last_digit && !rems_zero) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_q_pop     = 1'b0;
        n_neg       = r_neg;
        n_scaled    = r_scaled;
        n_num       = r_num;
        n_den       = r_den;
        n_wn        = r_wn;
        n_wd        = r_wd;
        n_rn        = r_rn;
        n_rd        = r_rd;
        n_cnt       = r_cnt;
        n_out_num   = r_out_num;
        n_out_den   = r_out_den;
        n_out_valid = r_out_valid && !i_pop;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop  = 1'b1;
                    n_neg    = i_q_item.neg;
                    n_scaled = PROD_W'(i_q_item.mag);
                    n_den    = GW'(1);
                end
            end
            S_SCALE: begin
                if (scale_more) begin
                    n_scaled = (r_scaled << 3) + (r_scaled << 1);
                    n_den    = (r_den << 3) + (r_den << 1);
                end
            end
            S_ROUND: begin
                n_num = GW'(rnd_sum[PROD_W:FRAC_BITS]);
            end
            S_HALVE: begin
                if (num_zero) begin
                    n_den = GW'(1);
                end else if (both_even) begin
                    n_num = r_num >> 1;
                    n_den = r_den >> 1;
                end else begin
                    n_wn  = r_num;
                    n_wd  = r_den;
                    n_rn  = 3'd0;
                    n_rd  = 3'd0;
                    n_cnt = '0;
                end
            end
            S_DIV5: begin
                n_wn  = quot_n;
                n_wd  = quot_d;
                n_rn  = step_n[2:0];
                n_rd  = step_d[2:0];
                n_cnt = r_cnt + 1'b1;
                if (last_digit && rems_zero) begin
                    n_num = quot_n;
                    n_den = quot_d;
                    n_rn  = 3'd0;
                    n_rd  = 3'd0;
                    n_cnt = '0;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_num   = num_signed[NUM_OUT_W-1:0];
                    n_out_den   = r_den[DEN_OUT_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_neg     <= n_neg;
        r_scaled  <= n_scaled;
        r_num     <= n_num;
        r_den     <= n_den;
        r_wn      <= n_wn;
        r_wd      <= n_wd;
        r_rn      <= n_rn;
        r_rd      <= n_rd;
        r_cnt     <= n_cnt;
        r_out_num <= n_out_num;
        r_out_den <= n_out_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### rtl/core/decimal_to_fraction_reducer.sv
// ----------------------------------------------------------------------------
// decimal_to_fraction_reducer: signed fixed-point value to reduced fraction
// Both sides behave as queues. A value is written with push while full is
// low; a result waits on o_numerator and o_denominator while empty is low
// and is removed with pop. The sign stays on the numerator and the
// denominator divides a power of ten.
// An input stage and a two-entry queue feed the reduction engine, so up to
// three further values are taken while one is being reduced. The engine
// handles one value at a time. Each divide-by-five pass runs over
// D = ceil(NUM_W / 4) radix-16 digits. The time a value holds the engine
// grows with the number of times ten is applied, the factors of two
// removed and the factors of five removed, and at default settings is
// dominated by the serial divide-by-five passes; a value that is zero or
// rounds to zero skips the halving and divide-by-five steps.
// Results pass through a single output register. While the receiver holds
// pop low the engine waits with its finished result, then the queue fills
// and full rises. Reset empties both queues and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_to_fraction_reducer
    import dtf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int DEN_LIMIT = MAX_DEN_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         push,
    output logic                        full,
    input  wire signed [VALUE_W-1:0]    i_value,
    output logic                        empty,
    input  wire                         pop,
    output logic signed [NUM_OUT_W-1:0] o_numerator,
    output logic [DEN_OUT_W-1:0]        o_denominator
);

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    t_item q_in_item;
    t_item q_out_item;

    dtf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_value  (i_value),
        .o_q_push (q_push),
        .o_q_item (q_in_item),
        .i_q_full (q_full)
    );

    dtf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out_item),
        .o_empty (q_empty)
    );

    dtf_back #(
        .FRAC_BITS (FRAC_BITS),
        .DEN_LIMIT (DEN_LIMIT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_item      (q_out_item),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_numerator   (o_numerator),
        .o_denominator (o_denominator)
    );

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_denominator != '0))
        else $error("zero denominator presented");

    a_reduced_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_numerator[0]) |-> o_denominator[0])
        else $error("fraction not reduced by two");

    a_pop_waits_engine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop) |-> !q_empty)
        else $error("engine took an item from an empty queue");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for decimal_to_fraction_reducer
// Fixed-point values are fed through the push side in random bursts. Each
// accepted value is reduced to a fraction by a behavioral model in this file,
// and the result is queued. Results are popped with a stall pattern of their
// own and compared field by field with the oldest queued fraction.
// ----------------------------------------------------------------------------
module tb_top
    import dtf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIRECTED_COUNT = 22;
    localparam int RANDOM_COUNT   = 1530;
    localparam int IDLE_LIMIT     = 20000;
    localparam int SETTLE_CYCLES  = 150;

    typedef struct packed {
        logic signed [NUM_OUT_W-1:0] num;
        logic [DEN_OUT_W-1:0]        den;
    } t_fraction;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         push;
    logic                         full;
    logic signed [VALUE_W-1:0]    i_value;
    logic                         empty;
    logic                         pop;
    logic signed [NUM_OUT_W-1:0]  o_numerator;
    logic [DEN_OUT_W-1:0]         o_denominator;

    logic [VALUE_W-1:0] pending_values[$];
    t_fraction          expected_fractions[$];
    int unsigned        drain_points[$];
    int unsigned        values_issued;
    int unsigned        fail_count;
    int unsigned        idle_cycles;
    int unsigned        burst_left;
    int unsigned        gap_left;
    int unsigned        rx_cycle;
    int unsigned        rx_mode;
    logic               value_taken;

    decimal_to_fraction_reducer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_value       (i_value),
        .empty         (empty),
        .pop           (pop),
        .o_numerator   (o_numerator),
        .o_denominator (o_denominator)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = ~i_clk;
    end

    function automatic t_fraction reduce_to_fraction(input logic [VALUE_W-1:0] v);
        t_fraction   f;
        logic        neg;
        logic [31:0] mag32;
        logic [63:0] mag;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        logic [63:0] fmask;
        neg   = v[VALUE_W-1];
        mag32 = neg ? (~v + 32'd1) : v;
        mag   = {32'd0, mag32};
        fmask = (64'd1 << FRAC_BITS_DEF) - 64'd1;
        den   = 64'd1;
        if (mag == 64'd0) begin
            f.num = '0;
            f.den = DEN_OUT_W'(1);
            return f;
        end
        while (((mag * den) & fmask) != 64'd0 && den < 64'(MAX_DEN_DEF)) begin
            den = den * 64'd10;
        end
        num = (mag * den + (64'd1 << (FRAC_BITS_DEF - 1))) >> FRAC_BITS_DEF;
        a = num;
        b = den;
        while (b != 64'd0) begin
            r = a % b;
            a = b;
            b = r;
        end
        num = num / a;
        den = den / a;
        if (neg) begin
            num = 64'd0 - num;
        end
        f.num = num[NUM_OUT_W-1:0];
        f.den = den[DEN_OUT_W-1:0];
        return f;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        int unsigned        kind;
        int unsigned        frac_bits;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            v = $urandom;
        end else if (kind < 6) begin
            // Short binary fractions end as exact decimals within the cap.
            frac_bits = $urandom_range(0, 4);
            v = ($urandom_range(0, 2000) << 16)
                | (($urandom & ((32'd1 << frac_bits) - 32'd1)) << (16 - frac_bits));
        end else if (kind == 6) begin
            v = $urandom_range(0, 16);
        end else if (kind == 7) begin
            v = {1'b0, 15'h7FFF - 15'($urandom_range(0, 7)), 16'($urandom)};
        end else begin
            frac_bits = $urandom_range(1, 16);
            v = ($urandom & 32'h7FFF0000) | ($urandom & ((32'd1 << frac_bits) - 32'd1));
        end
        if ($urandom_range(0, 1) == 1) begin
            v = ~v + 32'd1;
        end
        return v;
    endfunction

    // Accepted requests on the push side get their fraction queued here.
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            expected_fractions.push_back(reduce_to_fraction(i_value));
            value_taken <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push        <= 1'b0;
            value_taken <= 1'b0;
        end else if (push && !value_taken) begin
            push <= 1'b1;
        end else begin
            value_taken <= 1'b0;
            if (drain_points.size() != 0 && values_issued == drain_points[0]
                && expected_fractions.size() == 0) begin
                void'(drain_points.pop_front());
            end
            if (gap_left != 0) begin
                push     <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_values.size() == 0) begin
                push <= 1'b0;
            end else if (drain_points.size() != 0 && values_issued == drain_points[0]) begin
                push <= 1'b0;
            end else begin
                push          <= 1'b1;
                i_value       <= pending_values.pop_front();
                values_issued <= values_issued + 1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop      <= 1'b0;
            rx_cycle <= 0;
            rx_mode  <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 256 == 0) begin
                rx_mode <= $urandom_range(0, 3);
            end
            case (rx_mode)
                0: begin
                    pop <= 1'b1;
                end
                1: begin
                    pop <= 1'($urandom_range(0, 1));
                end
                2: begin
                    pop <= ($urandom_range(0, 7) == 0);
                end
                default: begin
                    pop <= (rx_cycle % 96) < 10;
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_fraction want;
        if (i_rst_n && pop && !empty) begin
            if (expected_fractions.size() == 0) begin
                $display("%0t: unexpected result %0d/%0d", $time,
                         o_numerator, o_denominator);
                fail_count = fail_count + 1;
            end else begin
                want = expected_fractions.pop_front();
                if (o_numerator !== want.num) begin
                    $display("%0t: numerator expected %0d, actual %0d", $time,
                             want.num, o_numerator);
                    fail_count = fail_count + 1;
                end
                if (o_denominator !== want.den) begin
                    $display("%0t: denominator expected %0d, actual %0d", $time,
                             want.den, o_denominator);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("decimal_to_fraction_reducer: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        i_value       = '0;
        value_taken   = 1'b0;
        values_issued = 0;
        fail_count    = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        gap_left      = 0;
        rx_cycle      = 0;
        rx_mode       = 0;

        // Zero, both ends of the range, exact values, halves at the cap and
        // tiny values that round to zero.
        pending_values = '{32'h00000000, 32'h00000001, 32'hFFFFFFFF, 32'h7FFFFFFF,
                           32'h80000000, 32'h80000001, 32'h00010000, 32'hFFFF0000,
                           32'h00008000, 32'hFFFF8000, 32'h00004000, 32'h00001999,
                           32'h00000800, 32'hFFFFF800, 32'h00000002, 32'hFFFFFFFE,
                           32'h0003243F, 32'hFFFCDBC1, 32'h7FFF0000, 32'h00002000,
                           32'h00001000, 32'h55555555};
        for (int i = 0; i < RANDOM_COUNT; i++) begin
            pending_values.push_back(random_value());
        end
        drain_points = '{DIRECTED_COUNT, DIRECTED_COUNT + RANDOM_COUNT / 2};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_values.size() != 0 || (push && !value_taken)
               || expected_fractions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_fractions.size() == 0) begin
            $display("decimal_to_fraction_reducer: match");
        end else begin
            $display("decimal_to_fraction_reducer: mismatch");
        end
        $finish;
    end

endmodule
